### design/lru_page_replacement_defines.svh
// Assertion macros used by the LRU page replacement module.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LRUPR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("LRU page replacement: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("LRU page replacement: next-cycle check failed");

`endif

### design/lrupr_pkg.sv
// Types and constants shared by the LRU page replacement design.
package lrupr_pkg;

	localparam int FRAMES      = 16;
	localparam int FRAME_IDX_W = $clog2(FRAMES);
	localparam int FRAME_CNT_W = FRAME_IDX_W + 1;
	localparam int PAGE_BITS   = 16;
	localparam int RANK_W      = 4;
	localparam int FAULT_W     = 32;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_FIU_W   = 5;

	localparam logic [RANK_W-1:0]      RANK_MAX        = '1;
	localparam logic [FAULT_W-1:0]     FAULT_MAX       = '1;
	localparam logic [CFG_FIU_W-1:0]   FRAMES_IN_USE_RST = CFG_FIU_W'(FRAMES);
	localparam logic [FRAME_CNT_W-1:0] FRAMES_CNT      = FRAME_CNT_W'(FRAMES);

	// Register index codes (word address bit above the byte offset).
	localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

	// Input beat: one page reference.
	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
		logic                 last_of_string;
	} req_t;

	// Result beat.
	typedef struct packed {
		logic                   hit;
		logic [FRAME_IDX_W-1:0] frame_slot;
		logic                   evicted_valid;
		logic [PAGE_BITS-1:0]   evicted_page;
		logic [FAULT_W-1:0]     fault_count;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

### design/lru_page_replacement.sv
// LRU page replacement engine: sequential frame walk, rank update and APB register.
//
//  channel   | direction | handshake            | beat
//  ----------+-----------+----------------------+----------------------------------
//  request   | in        | start high, busy low | req (page_number, last_of_string)
//  result    | out       | done, one cycle      | rsp (hit, slot, eviction, faults)
//  register  | in/out    | APB, pready always 1 | frames_in_use at address 0
//
// A reference walks the frames in use one per cycle through a single page comparator
// fed by the page RAM's registered read port. A miss walks every frame in use, a hit
// stops the walk at the matching frame; done follows in the first cycle that busy is
// low. Reset empties all frames and sets sixteen frames in use. The receiver cannot
// stall results.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lrupr_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [lrupr_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [lrupr_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                              pready,
	input  logic                              start,
	input  lrupr_pkg::req_t                   req,
	output logic                              busy,
	output logic                              done,
	output lrupr_pkg::rsp_t                   rsp
);

	import lrupr_pkg::*;

	state_t                 state_q, state_d;
	logic [CFG_FIU_W-1:0]   frames_cfg_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic                   last_q;
	logic [FRAME_CNT_W-1:0] n_q;
	logic [FRAME_IDX_W-1:0] idx_q;
	logic [FRAME_IDX_W-1:0] cmp_idx_q;
	logic                   cmp_v_q;
	logic                   valid_q [FRAMES];
	logic [RANK_W-1:0]      rank_q [FRAMES];
	logic [FAULT_W-1:0]     faults_q;
	logic                   hit_q;
	logic [FRAME_IDX_W-1:0] hit_slot_q;
	logic                   empty_found_q;
	logic [FRAME_IDX_W-1:0] empty_slot_q;
	logic [RANK_W-1:0]      best_rank_q;
	logic [FRAME_IDX_W-1:0] lru_slot_q;
	logic [PAGE_BITS-1:0]   lru_page_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic [PAGE_BITS-1:0]   ram_rdata;
	logic                   ram_we;
	logic [FRAME_IDX_W-1:0] upd_slot;
	logic                   frame_match;
	logic                   cmp_last;
	logic                   cfg_wr;
	logic [FRAME_CNT_W-1:0] n_clamped;
	logic [RANK_W-1:0]      hit_rank;
	logic [FAULT_W-1:0]     faults_next;
	logic                   valid_d [FRAMES];
	logic [RANK_W-1:0]      rank_d [FRAMES];

	// Page store, written on a fault and read one frame per cycle during the walk.
	lrupr_ram #(
		.WIDTH(PAGE_BITS),
		.DEPTH(FRAMES)
	) u_page_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(upd_slot),
		.wdata(page_q),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[CFG_ADDR_W-1] == REG_FRAMES_IN_USE);
	assign prdata = (paddr[CFG_ADDR_W-1] == REG_FRAMES_IN_USE)
		? CFG_DATA_W'(frames_cfg_q) : '0;

	// Frames in use, held to the range one to FRAMES.
	always_comb begin
		if (frames_cfg_q == '0) begin
			n_clamped = FRAME_CNT_W'(1);
		end else if (CFG_FIU_W'(frames_cfg_q) > CFG_FIU_W'(FRAMES_CNT)) begin
			n_clamped = FRAMES_CNT;
		end else begin
			n_clamped = FRAME_CNT_W'(frames_cfg_q);
		end
	end

	// Compare of the frame whose page has just come out of the RAM.
	assign frame_match = valid_q[cmp_idx_q] && (ram_rdata == page_q);
	assign cmp_last    = ({1'b0, cmp_idx_q} == (n_q - FRAME_CNT_W'(1)));
	assign hit_rank    = rank_q[hit_slot_q];
	assign faults_next = (faults_q != FAULT_MAX) ? faults_q + FAULT_W'(1) : faults_q;

	// Frame chosen for this reference.
	always_comb begin
		if (hit_q) begin
			upd_slot = hit_slot_q;
		end else if (empty_found_q) begin
			upd_slot = empty_slot_q;
		end else begin
			upd_slot = lru_slot_q;
		end
	end

	// Sequencer: next state and RAM write enable.
	always_comb begin
		state_d = state_q;
		ram_we  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cmp_v_q && (frame_match || cmp_last)) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				ram_we  = !hit_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Valid bits and ranks: other valid frames in use age; on a hit only newer ones do.
	always_comb begin
		for (int j = 0; j < FRAMES; j++) begin
			valid_d[j] = valid_q[j];
			rank_d[j]  = rank_q[j];
			if ((FRAME_CNT_W'(j) < n_q) && (FRAME_IDX_W'(j) != upd_slot) && valid_q[j]) begin
				if ((!hit_q || (rank_q[j] < hit_rank)) && (rank_q[j] != RANK_MAX)) begin
					rank_d[j] = rank_q[j] + RANK_W'(1);
				end
			end
			if (FRAME_IDX_W'(j) == upd_slot) begin
				valid_d[j] = 1'b1;
				rank_d[j]  = '0;
			end
			if (last_q) begin
				valid_d[j] = 1'b0;
				rank_d[j]  = '0;
			end
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Register file, walk bookkeeping, frame table and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q  <= FRAMES_IN_USE_RST;
			page_q        <= '0;
			last_q        <= 1'b0;
			n_q           <= FRAMES_CNT;
			idx_q         <= '0;
			cmp_idx_q     <= '0;
			cmp_v_q       <= 1'b0;
			faults_q      <= '0;
			hit_q         <= 1'b0;
			hit_slot_q    <= '0;
			empty_found_q <= 1'b0;
			empty_slot_q  <= '0;
			best_rank_q   <= '0;
			lru_slot_q    <= '0;
			lru_page_q    <= '0;
			done_q        <= 1'b0;
			rsp_q         <= '0;
			for (int j = 0; j < FRAMES; j++) begin
				valid_q[j] <= 1'b0;
				rank_q[j]  <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				frames_cfg_q <= pwdata[CFG_FIU_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						page_q        <= req.page_number;
						last_q        <= req.last_of_string;
						n_q           <= n_clamped;
						idx_q         <= '0;
						cmp_v_q       <= 1'b0;
						hit_q         <= 1'b0;
						empty_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q     <= idx_q + FRAME_IDX_W'(1);
					cmp_idx_q <= idx_q;
					cmp_v_q   <= 1'b1;
					if (cmp_v_q) begin
						if (frame_match) begin
							hit_q      <= 1'b1;
							hit_slot_q <= cmp_idx_q;
						end
						if (!valid_q[cmp_idx_q] && !empty_found_q) begin
							empty_found_q <= 1'b1;
							empty_slot_q  <= cmp_idx_q;
						end
						// Least recently used: first frame holding the largest rank.
						if ((cmp_idx_q == '0) || (rank_q[cmp_idx_q] > best_rank_q)) begin
							best_rank_q <= rank_q[cmp_idx_q];
							lru_slot_q  <= cmp_idx_q;
							lru_page_q  <= ram_rdata;
						end
					end
				end
				ST_UPDATE: begin
					for (int j = 0; j < FRAMES; j++) begin
						valid_q[j] <= valid_d[j];
						rank_q[j]  <= rank_d[j];
					end
					if (last_q) begin
						faults_q <= '0;
					end else if (!hit_q) begin
						faults_q <= faults_next;
					end
					done_q              <= 1'b1;
					rsp_q.hit           <= hit_q;
					rsp_q.frame_slot    <= upd_slot;
					rsp_q.evicted_valid <= !hit_q && !empty_found_q;
					rsp_q.evicted_page  <= (!hit_q && !empty_found_q) ? lru_page_q : '0;
					rsp_q.fault_count   <= hit_q ? faults_q : faults_next;
				end
				default: begin
					cmp_v_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Checks on the sequencer and the result.
	`LRUPR_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
	`LRUPR_ASSERT_NEXT(a_update_gives_result, state_q == ST_UPDATE, done && !busy)
	`LRUPR_ASSERT_NOW(a_evict_only_on_fault, done && rsp.evicted_valid, !rsp.hit)
	`LRUPR_ASSERT_NOW(a_fault_counted, done && !rsp.hit, rsp.fault_count != '0)
	`LRUPR_ASSERT_NOW(a_slot_in_use, state_q == ST_UPDATE, {1'b0, upd_slot} < n_q)

endmodule

### design/lrupr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lrupr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 1ps

module tb_top;
	import lrupr_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] FIU_ADDR = {REG_FRAMES_IN_USE, 2'b00};
	localparam int STALL_LIMIT = 4000;
	localparam int PRINT_CAP   = 60;

	typedef enum logic [1:0] {
		OP_REFERENCE,
		OP_SET_FRAMES,
		OP_SETTLE
	} stim_op_t;

	typedef struct {
		stim_op_t             op;
		req_t                 beat;
		logic [CFG_FIU_W-1:0] frames;
		bit                   steady;
	} stim_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr   = '0;
	logic [CFG_DATA_W-1:0] pwdata  = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  start   = 1'b0;
	req_t                  req     = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  rsp;

	stim_t page_refs_pending[$];
	rsp_t  lru_outcomes_due[$];
	int    refs_queued   = 0;
	int    issued_count  = 0;
	int    results_seen  = 0;
	int    error_count   = 0;
	int    gap_left      = 0;
	int    stall_cycles  = 0;

	// Shadow of the frame table and register, owned by the driver.
	logic [PAGE_BITS-1:0] shadow_page [FRAMES];
	logic                 shadow_valid[FRAMES];
	logic [RANK_W-1:0]    shadow_rank [FRAMES];
	logic [FAULT_W-1:0]   shadow_faults;
	logic [CFG_FIU_W-1:0] frames_cfg;

	always #1 clk = ~clk;

	lru_page_replacement u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp)
	);

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (error_count < PRINT_CAP)
			$display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	task automatic clear_frame_table();
		for (int j = 0; j < FRAMES; j++) begin
			shadow_page[j]  = '0;
			shadow_valid[j] = 1'b0;
			shadow_rank[j]  = '0;
		end
		shadow_faults = '0;
	endtask

	// Looks the page up, updates ranks and placement, and returns the result beat.
	task automatic predict_lru_reference(input req_t beat, output rsp_t outcome);
		int                n;
		int                slot;
		bit                found;
		bit                empty;
		logic [RANK_W-1:0] old_rank;
		logic [RANK_W-1:0] oldest;
		n = (frames_cfg == 0) ? 1 : (frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg);
		found = 1'b0;
		slot = 0;
		outcome = '0;
		for (int j = 0; j < n; j++)
			if (!found && shadow_valid[j] && shadow_page[j] == beat.page_number) begin
				found = 1'b1;
				slot = j;
			end
		if (found) begin
			// Frames more recent than the hit one age by one step.
			old_rank = shadow_rank[slot];
			for (int j = 0; j < n; j++)
				if (j != slot && shadow_valid[j] && shadow_rank[j] < old_rank &&
						shadow_rank[j] != RANK_MAX)
					shadow_rank[j]++;
			shadow_rank[slot] = '0;
		end else begin
			empty = 1'b0;
			for (int j = 0; j < n; j++)
				if (!empty && !shadow_valid[j]) begin
					empty = 1'b1;
					slot = j;
				end
			// No empty frame: the lowest-numbered frame of largest rank goes.
			if (!empty) begin
				oldest = '0;
				slot = 0;
				for (int j = 0; j < n; j++)
					if (j == 0 || shadow_rank[j] > oldest) begin
						oldest = shadow_rank[j];
						slot = j;
					end
				outcome.evicted_valid = 1'b1;
				outcome.evicted_page  = shadow_page[slot];
			end
			for (int j = 0; j < n; j++)
				if (j != slot && shadow_valid[j] && shadow_rank[j] != RANK_MAX)
					shadow_rank[j]++;
			shadow_page[slot]  = beat.page_number;
			shadow_valid[slot] = 1'b1;
			shadow_rank[slot]  = '0;
			if (shadow_faults != FAULT_MAX)
				shadow_faults++;
		end
		outcome.hit         = found;
		outcome.frame_slot  = slot[FRAME_IDX_W-1:0];
		outcome.fault_count = shadow_faults;
		if (beat.last_of_string)
			clear_frame_table();
	endtask

	// Driver: request beats, register writes and settle points from the pending queue.
	always @(posedge clk or negedge arst_n) begin
		stim_t nxt;
		rsp_t  outcome;
		logic  nx_start;
		logic  nx_psel;
		logic  nx_penable;
		bit    idle;
		if (!arst_n) begin
			start        <= 1'b0;
			psel         <= 1'b0;
			penable      <= 1'b0;
			pwrite       <= 1'b0;
			gap_left     <= 0;
			issued_count <= 0;
			clear_frame_table();
			frames_cfg = FRAMES_IN_USE_RST;
		end else begin
			nx_start   = start;
			nx_psel    = psel;
			nx_penable = penable;
			idle = !start && !busy && issued_count == results_seen;
			// A beat taken at this edge gets its result predicted now.
			if (start && !busy) begin
				predict_lru_reference(req, outcome);
				lru_outcomes_due.push_back(outcome);
				issued_count <= issued_count + 1;
				nx_start = 1'b0;
			end
			if (psel && penable && pready) begin
				frames_cfg = pwdata[CFG_FIU_W-1:0];
				nx_psel    = 1'b0;
				nx_penable = 1'b0;
				pwrite     <= 1'b0;
			end else if (psel) begin
				nx_penable = 1'b1;
			end else if (!nx_start && page_refs_pending.size() != 0) begin
				nxt = page_refs_pending[0];
				case (nxt.op)
					OP_REFERENCE: begin
						if (gap_left != 0) begin
							gap_left <= gap_left - 1;
						end else if (!nxt.steady && $urandom_range(99) < 10) begin
							gap_left <= $urandom_range(24);
						end else begin
							req      <= nxt.beat;
							nx_start = 1'b1;
							void'(page_refs_pending.pop_front());
						end
					end
					OP_SET_FRAMES: begin
						if (idle) begin
							nx_psel = 1'b1;
							pwrite  <= 1'b1;
							paddr   <= FIU_ADDR;
							pwdata  <= CFG_DATA_W'(nxt.frames);
							void'(page_refs_pending.pop_front());
						end
					end
					OP_SETTLE: begin
						if (idle)
							void'(page_refs_pending.pop_front());
					end
					default: begin
						void'(page_refs_pending.pop_front());
					end
				endcase
			end
			start   <= nx_start;
			psel    <= nx_psel;
			penable <= nx_penable;
		end
	end

	// Monitor: each result beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			results_seen <= results_seen + 1;
			if (lru_outcomes_due.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", 32'(rsp.frame_slot), 0);
			end else begin
				want = lru_outcomes_due.pop_front();
				if (rsp.hit !== want.hit)
					report_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
				if (rsp.frame_slot !== want.frame_slot)
					report_mismatch("frame_slot", 32'(rsp.frame_slot), 32'(want.frame_slot));
				if (rsp.evicted_valid !== want.evicted_valid)
					report_mismatch("evicted_valid", 32'(rsp.evicted_valid),
						32'(want.evicted_valid));
				if (rsp.evicted_page !== want.evicted_page)
					report_mismatch("evicted_page", 32'(rsp.evicted_page),
						32'(want.evicted_page));
				if (rsp.fault_count !== want.fault_count)
					report_mismatch("fault_count", rsp.fault_count, want.fault_count);
			end
		end
	end

	// Watchdog: ends the run after too long without any beat moving.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (psel && penable && pready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	task automatic add_reference(input logic [PAGE_BITS-1:0] page, input logic last);
		stim_t s;
		s.op                  = OP_REFERENCE;
		s.beat.page_number    = page;
		s.beat.last_of_string = last;
		s.frames              = '0;
		s.steady              = (refs_queued >= 450 && refs_queued < 620);
		page_refs_pending.push_back(s);
		refs_queued++;
	endtask

	task automatic add_frames_write(input logic [CFG_FIU_W-1:0] value);
		stim_t s;
		s.op     = OP_SET_FRAMES;
		s.beat   = '0;
		s.frames = value;
		s.steady = 1'b0;
		page_refs_pending.push_back(s);
	endtask

	task automatic add_settle();
		stim_t s;
		s.op     = OP_SETTLE;
		s.beat   = '0;
		s.frames = '0;
		s.steady = 1'b0;
		page_refs_pending.push_back(s);
	endtask

	initial begin
		logic [PAGE_BITS-1:0] working_set[32];
		int                   ws_size;
		int                   str_len;
		logic [CFG_FIU_W-1:0] fiu;
		logic [PAGE_BITS-1:0] page;

		// Two frames: fill, hit, replace least recent, end of string, then fresh string.
		add_frames_write(5'd2);
		add_reference(16'h0000, 1'b0);
		add_reference(16'hFFFF, 1'b0);
		add_reference(16'h0000, 1'b0);
		add_reference(16'h5A5A, 1'b0);
		add_reference(16'hFFFF, 1'b0);
		add_reference(16'hA5A5, 1'b1);
		add_reference(16'hFFFF, 1'b0);
		add_settle();
		// A zero register acts as a single frame.
		add_frames_write(5'd0);
		add_reference(16'h1111, 1'b0);
		add_reference(16'h1111, 1'b0);
		// Values above the frame count act as all frames.
		add_frames_write(5'd31);
		add_reference(16'h2222, 1'b0);
		add_reference(16'h8001, 1'b0);
		// Shrink and regrow mid-string so stale and tied ranks meet.
		add_frames_write(5'd3);
		add_reference(16'h0300, 1'b0);
		add_reference(16'h0301, 1'b0);
		add_frames_write(5'd1);
		add_reference(16'h0302, 1'b0);
		add_reference(16'h0303, 1'b0);
		add_frames_write(5'd16);
		add_reference(16'h0300, 1'b0);
		add_reference(16'h0304, 1'b0);
		add_reference(16'h2222, 1'b0);
		add_reference(16'h0305, 1'b0);
		add_reference(16'h0301, 1'b1);
		add_frames_write(5'd17);

		// Random strings over a small working set, with occasional strays.
		while (refs_queued < 920) begin
			ws_size = $urandom_range(1, 20);
			for (int k = 0; k < ws_size; k++)
				working_set[k] = PAGE_BITS'($urandom_range(0, 65535));
			str_len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
			for (int i = 0; i < str_len; i++) begin
				if ($urandom_range(39) == 0) begin
					case ($urandom_range(5))
						0:       fiu = 5'd1;
						1:       fiu = 5'd16;
						2:       fiu = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
						default: fiu = 5'($urandom_range(1, 16));
					endcase
					add_frames_write(fiu);
				end
				if ($urandom_range(99) == 0)
					add_settle();
				if ($urandom_range(99) < 85)
					page = working_set[$urandom_range(0, ws_size - 1)];
				else
					page = PAGE_BITS'($urandom_range(0, 65535));
				add_reference(page, (i == str_len - 1) && $urandom_range(9) != 0);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (page_refs_pending.size() != 0 || start || psel ||
				issued_count != results_seen)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (lru_outcomes_due.size() != 0)
			report_mismatch("results never delivered", 0, lru_outcomes_due.size());

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
